// File: hdl/page_slot_allocator_defines.svh
// Assertion macros used by the page slot allocator datapath.
`ifndef PAGE_SLOT_ALLOCATOR_DEFINES_SVH
`define PAGE_SLOT_ALLOCATOR_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define PSA_ASSERT_ALWAYS(lbl, clock, reset, cond, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define PSA_ASSERT_IMPLIES(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSA_ASSERT_NEXT(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/psa_pkg.sv
// Types and constants shared by the page slot allocator modules.
`default_nettype none
package psa_pkg;

  localparam int MAX_PAGES = 64;
  localparam int MAX_SLOTS = 64;
  // Slots per bitmap row: the slot limit, never more than a 64-bit row.
  localparam int ROW_BITS  = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

  localparam int PAGE_W = 7;
  localparam int SLOT_W = 6;
  localparam int CNT_W  = 7;
  localparam int PIDX_W = $clog2(MAX_PAGES);
  localparam int SPP_W  = 7;
  localparam int RSZ_W  = 13;
  localparam int OFF_W  = 16;
  localparam int CIDX_W = 2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_SLOTS_PER_PAGE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_RECORD_SIZE    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DATA_START     = 2'd2;

  // Operation kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef struct packed {
    logic init_link;
    logic accept;
    logic exec;
    logic finish;
  } psa_cmd_t;

  typedef struct packed {
    logic out_free;
  } psa_stat_t;

endpackage
`default_nettype wire

// File: hdl/page_slot_allocator.sv
// Top level of the page slot allocator.
// Record slot allocator over up to 64 pages of up to 64 slots. Insert
// (kind 0) takes the lowest free slot of the free-list head page; delete
// (kind 1) frees a given page and slot. Each item gives one result. An
// item's page row and link are read from on-chip memory, then updated
// and written back; the byte offset multiply happens while the result
// is loaded, which overlaps the read of the next item, so the block
// takes a new item before its last result is out while results are
// taken promptly. After reset the block clears the first page's link
// before it accepts an item. Configuration writes are always accepted
// and must only be made while the block is idle.
`default_nettype none
module page_slot_allocator
  import psa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              kind,
  input  wire logic [PAGE_W-1:0] page_number,
  input  wire logic [SLOT_W-1:0] slot_number,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic [PAGE_W-1:0]      result_page,
  output logic [SLOT_W-1:0]      result_slot,
  output logic [OFF_W-1:0]       byte_offset,
  output logic [CNT_W-1:0]       records_on_page,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [OFF_W-1:0]  cfg_data
);

  psa_cmd_t  cmd;
  psa_stat_t stat;

  assign cfg_ready = 1'b1;

  psa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psa_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .kind            (kind),
    .page_number     (page_number),
    .slot_number     (slot_number),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .result_page     (result_page),
    .result_slot     (result_slot),
    .byte_offset     (byte_offset),
    .records_on_page (records_on_page)
  );

endmodule
`default_nettype wire

// File: hdl/psa_ctrl.sv
// Sequencer that steps each item through read, update and result load.
`default_nettype none
module psa_ctrl
  import psa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire psa_stat_t stat,
  output psa_cmd_t       cmd
);

  localparam logic [1:0] S_INIT   = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_EXEC   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init_link = 1'b1;
        state_next    = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // The next item is taken in the same cycle as the result is loaded.
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          in_ready   = 1'b1;
          state_next = in_valid ? S_EXEC : S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
    cmd.accept = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/psa_datapath.sv
// Page rows, free list, configuration registers and the result register.
`default_nettype none
`include "page_slot_allocator_defines.svh"
module psa_datapath
  import psa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire psa_cmd_t          cmd,
  output psa_stat_t              stat,
  input  wire logic              kind,
  input  wire logic [PAGE_W-1:0] page_number,
  input  wire logic [SLOT_W-1:0] slot_number,
  input  wire logic              cfg_write,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [OFF_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic [PAGE_W-1:0]      result_page,
  output logic [SLOT_W-1:0]      result_slot,
  output logic [OFF_W-1:0]       byte_offset,
  output logic [CNT_W-1:0]       records_on_page
);

  localparam int PROD_W = RSZ_W + SLOT_W;
  localparam int SUM_W  = PROD_W + 1;

  // Configuration registers.
  logic [SPP_W-1:0] slots_per_page;
  logic [RSZ_W-1:0] record_size;
  logic [OFF_W-1:0] data_start;

  // Free list control.
  logic [PAGE_W-1:0] free_head;
  logic [PAGE_W-1:0] free_head_next;
  logic [PAGE_W-1:0] pages_used;
  logic [PAGE_W-1:0] pages_used_next;

  // Page storage: bitmap and record count share one row; links are separate.
  logic [ROW_BITS-1:0] bits_mem  [MAX_PAGES];
  logic [CNT_W-1:0]    count_mem [MAX_PAGES];
  logic [PAGE_W-1:0]   link_mem  [MAX_PAGES];
  logic [MAX_PAGES-1:0] row_valid;

  // Item held while it is worked on.
  logic              req_kind;
  logic [PAGE_W-1:0] req_page;
  logic [SLOT_W-1:0] req_slot;
  logic [PIDX_W-1:0] req_idx;

  logic [PAGE_W-1:0]   addr_page;
  logic [PAGE_W-1:0]   addr_sum;
  logic [ROW_BITS-1:0] rd_bits_raw;
  logic [CNT_W-1:0]    rd_count_raw;
  logic [PAGE_W-1:0]   rd_link;
  logic                rd_valid;

  logic [CNT_W-1:0]    usable_n;
  logic [ROW_BITS-1:0] usable_mask;
  logic [ROW_BITS-1:0] cur_bits;
  logic [CNT_W-1:0]    cur_count;
  logic [ROW_BITS-1:0] free_bits;
  logic                any_free;
  logic [ROW_BITS-1:0] lowest;
  logic [SLOT_W-1:0]   low_slot;
  logic [ROW_BITS-1:0] ins_bits;
  logic                ins_full;
  logic [ROW_BITS-1:0] del_mask;
  logic                del_bad;
  logic                del_set;
  logic                head_ok;
  logic [PAGE_W-1:0]   link_next;
  logic                do_unlink;

  logic                row_we;
  logic [ROW_BITS-1:0] row_wbits;
  logic [CNT_W-1:0]    row_wcount;
  logic                link_we;
  logic [PIDX_W-1:0]   link_waddr;
  logic [PAGE_W-1:0]   link_wdata;
  logic [PIDX_W-1:0]   new_idx;

  logic [1:0]        res_status;
  logic [1:0]        res_status_next;
  logic [PAGE_W-1:0] res_page;
  logic [PAGE_W-1:0] res_page_next;
  logic [SLOT_W-1:0] res_slot;
  logic [SLOT_W-1:0] res_slot_next;
  logic [CNT_W-1:0]  res_count;
  logic [CNT_W-1:0]  res_count_next;

  logic [PROD_W-1:0] off_prod;
  logic [SUM_W-1:0]  off_sum;
  logic [OFF_W-1:0]  off_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_per_page <= SPP_W'(64);
      record_size    <= RSZ_W'(64);
      data_start     <= OFF_W'(16);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SLOTS_PER_PAGE: slots_per_page <= cfg_data[SPP_W-1:0];
        CFG_RECORD_SIZE:    record_size    <= cfg_data[RSZ_W-1:0];
        CFG_DATA_START:     data_start     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Row address: the list head for an insert, the named page for a delete.
  assign addr_page = (kind == KIND_DELETE) ? page_number : free_head;
  assign addr_sum  = addr_page - PAGE_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_kind     <= kind;
      req_page     <= page_number;
      req_slot     <= slot_number;
      req_idx      <= addr_sum[PIDX_W-1:0];
      rd_bits_raw  <= bits_mem[addr_sum[PIDX_W-1:0]];
      rd_count_raw <= count_mem[addr_sum[PIDX_W-1:0]];
      rd_link      <= link_mem[addr_sum[PIDX_W-1:0]];
      rd_valid     <= row_valid[addr_sum[PIDX_W-1:0]];
    end
  end

  always_comb begin
    if (slots_per_page == '0) begin
      usable_n = CNT_W'(1);
    end else if (CNT_W'(slots_per_page) > CNT_W'(ROW_BITS)) begin
      usable_n = CNT_W'(ROW_BITS);
    end else begin
      usable_n = CNT_W'(slots_per_page);
    end
    for (int i = 0; i < ROW_BITS; i++) begin
      usable_mask[i] = CNT_W'(i) < usable_n;
    end
  end

  // A row never written since reset reads as an empty page.
  assign cur_bits  = rd_valid ? rd_bits_raw : '0;
  assign cur_count = rd_valid ? rd_count_raw : '0;
  assign free_bits = ~cur_bits & usable_mask;
  assign any_free  = |free_bits;
  assign lowest    = free_bits & (~free_bits + ROW_BITS'(1));
  assign ins_bits  = cur_bits | lowest;
  assign ins_full  = ~|(~ins_bits & usable_mask);

  always_comb begin
    low_slot = '0;
    for (int b = 0; b < SLOT_W; b++) begin
      for (int i = 0; i < ROW_BITS; i++) begin
        if (((i >> b) & 1) == 1) begin
          low_slot[b] = low_slot[b] | lowest[i];
        end
      end
    end
  end

  assign del_mask = ROW_BITS'(1) << req_slot;
  assign del_set  = |(cur_bits & del_mask);
  assign del_bad  = (req_page == '0) || (req_page > pages_used) ||
                    (req_page > PAGE_W'(MAX_PAGES)) ||
                    (CNT_W'(req_slot) >= usable_n);
  assign head_ok  = (free_head != '0) && (free_head <= PAGE_W'(MAX_PAGES));
  assign link_next = ((rd_link == '0) || (rd_link > PAGE_W'(MAX_PAGES))) ? '0 : rd_link;
  assign new_idx   = pages_used[PIDX_W-1:0];

  always_comb begin
    free_head_next  = free_head;
    pages_used_next = pages_used;
    row_we          = 1'b0;
    row_wbits       = cur_bits;
    row_wcount      = cur_count;
    link_we         = 1'b0;
    link_waddr      = req_idx;
    link_wdata      = '0;
    do_unlink       = 1'b0;
    res_status_next = ST_OK;
    res_page_next   = '0;
    res_slot_next   = '0;
    res_count_next  = '0;

    if (req_kind == KIND_INSERT) begin
      if (!head_ok) begin
        free_head_next  = '0;
        res_status_next = ST_FULL;
      end else if (!any_free) begin
        // Head page has no usable slot left, e.g. after the slot limit shrank.
        do_unlink       = 1'b1;
        res_status_next = ST_FULL;
      end else begin
        row_we         = 1'b1;
        row_wbits      = ins_bits;
        row_wcount     = cur_count + CNT_W'(1);
        do_unlink      = ins_full;
        res_page_next  = free_head;
        res_slot_next  = low_slot;
        res_count_next = cur_count + CNT_W'(1);
      end
    end else begin
      if (del_bad) begin
        res_status_next = ST_BAD;
      end else if (!del_set) begin
        res_status_next = ST_EMPTY;
        res_page_next   = req_page;
        res_slot_next   = req_slot;
        res_count_next  = cur_count;
      end else begin
        row_we         = 1'b1;
        row_wbits      = cur_bits & ~del_mask;
        row_wcount     = cur_count - CNT_W'(1);
        res_page_next  = req_page;
        res_slot_next  = req_slot;
        res_count_next = cur_count - CNT_W'(1);
        // A page that was full goes back to the head of the list.
        if (!any_free && (req_page != free_head)) begin
          link_we        = 1'b1;
          link_waddr     = req_idx;
          link_wdata     = free_head;
          free_head_next = req_page;
        end
      end
    end

    // An unlinked page's own link is left stale; it is rewritten on relink.
    if (do_unlink) begin
      if ((link_next == '0) && (pages_used < PAGE_W'(MAX_PAGES))) begin
        pages_used_next = pages_used + PAGE_W'(1);
        free_head_next  = pages_used + PAGE_W'(1);
        link_we         = 1'b1;
        link_waddr      = new_idx;
        link_wdata      = '0;
      end else begin
        free_head_next = link_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && row_we) begin
      bits_mem[req_idx]  <= row_wbits;
      count_mem[req_idx] <= row_wcount;
    end
  end

  // Page one exists from reset, so its link is cleared once before any item.
  always_ff @(posedge clk) begin
    if (cmd.init_link) begin
      link_mem[0] <= '0;
    end else if (cmd.exec && link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
  end

  // A freshly created page has never been written, so its row still reads as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      free_head  <= PAGE_W'(1);
      pages_used <= PAGE_W'(1);
    end else if (cmd.exec) begin
      free_head  <= free_head_next;
      pages_used <= pages_used_next;
      if (row_we) begin
        row_valid[req_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= res_status_next;
      res_page   <= res_page_next;
      res_slot   <= res_slot_next;
      res_count  <= res_count_next;
    end
  end

  assign off_prod = record_size * res_slot;
  assign off_sum  = SUM_W'(data_start) + SUM_W'(off_prod);
  assign off_sat  = (off_sum > SUM_W'(16'hFFFF)) ? 16'hFFFF : off_sum[OFF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status          <= res_status;
      result_page     <= res_page;
      result_slot     <= res_slot;
      records_on_page <= res_count;
      byte_offset     <= ((res_status == ST_OK) || (res_status == ST_EMPTY)) ? off_sat : '0;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  `PSA_ASSERT_ALWAYS(a_head_in_range, clk, rst, free_head <= pages_used, "free list head beyond the pages in use")
  `PSA_ASSERT_ALWAYS(a_pages_bounded, clk, rst, (pages_used != '0) && (pages_used <= PAGE_W'(MAX_PAGES)), "page count out of range")
  `PSA_ASSERT_IMPLIES(a_finish_free, clk, rst, cmd.finish, !out_valid || out_ready, "result loaded over an item not yet taken")
  `PSA_ASSERT_NEXT(a_exec_then_finish, clk, rst, cmd.exec, !cmd.exec, "update step not followed by a result step")

endmodule
`default_nettype wire
